@@ hdl/fifo_handle_pool_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// fifo_handle_pool_allocator_assert
// Assertion macros shared by the handle pool allocator modules.
// ----------------------------------------------------------------------------
`ifndef FIFO_HANDLE_POOL_ALLOCATOR_ASSERT_SVH
`define FIFO_HANDLE_POOL_ALLOCATOR_ASSERT_SVH

// condition must hold at every edge out of reset
`define FHPA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define FHPA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FHPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/fhpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fhpa_pkg
// Types and codes for the handle pool allocator.
// ----------------------------------------------------------------------------
package fhpa_pkg;

	localparam int POOL_SIZE_DEF = 64;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_TRY   = 2'd1,
		OP_FREE  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NONE      = 2'd1,
		ST_EXHAUSTED = 2'd2,
		ST_NOT_ALLOC = 2'd3
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fq_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fq_sts_t;

endpackage

@@ hdl/fhpa_free_fifo.sv @@
// ----------------------------------------------------------------------------
// fhpa_free_fifo
// Free-handle FIFO; the head entry is prefetched into a register every cycle.
// ----------------------------------------------------------------------------
`include "fifo_handle_pool_allocator_assert.svh"

module fhpa_free_fifo
	import fhpa_pkg::*;
#(
	parameter int POOL_SIZE = POOL_SIZE_DEF,
	parameter int HW        = $clog2(POOL_SIZE),
	parameter int CW        = $clog2(POOL_SIZE + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fq_ctl_t       ctl,
	input  logic [HW-1:0] wdata,
	output logic [HW-1:0] head_data,
	output fq_sts_t       sts
);

	logic [HW-1:0] free_mem [POOL_SIZE];
	logic [HW-1:0] head_q;
	logic [HW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [HW-1:0] head_nxt;
	logic [HW-1:0] tail_nxt;
	logic [HW-1:0] rd_addr;
	logic [HW-1:0] rdata_q;

	assign head_nxt = (head_q == HW'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == HW'(POOL_SIZE - 1)) ? '0 : tail_q + 1'b1;
	assign rd_addr  = ctl.pop ? head_nxt : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q <= head_nxt;
			end
			if (ctl.push) begin
				tail_q <= tail_nxt;
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			free_mem[tail_q] <= wdata;
		end
	end

	// write-first bypass keeps the prefetched head coherent
	always_ff @(posedge clk) begin
		if (ctl.push && (tail_q == rd_addr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= free_mem[rd_addr];
		end
	end

	assign head_data = rdata_q;
	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(POOL_SIZE));

	`FHPA_ASSERT_IMPLY(a_pop_nonempty, ctl.pop, count_q != '0, "pop from empty free list")
	`FHPA_ASSERT_IMPLY(a_push_nonfull, ctl.push, count_q != CW'(POOL_SIZE), "push to full free list")
	`FHPA_ASSERT_IMPLY(a_empty_ptrs, count_q == '0, head_q == tail_q, "empty list with split pointers")

endmodule

@@ hdl/fifo_handle_pool_allocator.sv @@
// Requests are registered in stage s1, results in the output register.
// Throughput: one beat per cycle unless m_tready stalls the output; each
// request pops/pushes at most one free-list entry, whose head is prefetched.
// Reset (arst_n low) clears the allocated map, free-list pointers and fresh
// counter at once; the free-list memory needs no clearing pass.
// ----------------------------------------------------------------------------
// fifo_handle_pool_allocator
// Handle pool allocator: FIFO free list plus fresh-handle counter.
// ----------------------------------------------------------------------------
`include "fifo_handle_pool_allocator_assert.svh"

module fifo_handle_pool_allocator
	import fhpa_pkg::*;
#(
	parameter int POOL_SIZE = POOL_SIZE_DEF,
	parameter int HW        = $clog2(POOL_SIZE),
	parameter int CW        = $clog2(POOL_SIZE + 1),
	parameter int IN_W      = ((HW + 2 + 7) / 8) * 8,
	parameter int OUT_W     = ((HW + 2 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // operation[1:0], release_handle
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // granted_handle, status[1:0]
);

	logic                 vld_s1;
	op_t                  op_s1;
	logic [HW-1:0]        rel_s1;
	logic                 adv;

	logic [POOL_SIZE-1:0] alloc_map_q;
	logic [CW-1:0]        fresh_q;
	logic                 m_vld_q;
	logic [HW-1:0]        grant_q;
	status_t              status_q;

	fq_ctl_t              fq_ctl;
	fq_sts_t              fq_sts;
	logic [HW-1:0]        head_data;

	logic [HW-1:0]        grant;
	status_t              status;
	logic                 set_en;
	logic [HW-1:0]        set_idx;
	logic                 clr_en;
	logic                 fresh_inc;
	logic                 pop_req;
	logic                 push_req;
	logic                 rel_ok;

	assign adv      = vld_s1 && (!m_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= op_t'(s_tdata[1:0]);
			rel_s1 <= s_tdata[HW+1:2];
		end
	end

	assign rel_ok = {1'b0, rel_s1} < (HW + 1)'(POOL_SIZE);

	always_comb begin
		grant     = '0;
		status    = ST_OK;
		set_en    = 1'b0;
		set_idx   = head_data;
		clr_en    = 1'b0;
		fresh_inc = 1'b0;
		pop_req   = 1'b0;
		push_req  = 1'b0;
		case (op_s1)
			OP_ALLOC: begin
				if (!fq_sts.empty) begin
					pop_req = 1'b1;
					grant   = head_data;
					set_en  = 1'b1;
				end else if (fresh_q < CW'(POOL_SIZE)) begin
					grant     = fresh_q[HW-1:0];
					set_idx   = fresh_q[HW-1:0];
					set_en    = 1'b1;
					fresh_inc = 1'b1;
				end else begin
					status = ST_EXHAUSTED;
				end
			end
			OP_TRY: begin
				if (!fq_sts.empty) begin
					pop_req = 1'b1;
					grant   = head_data;
					set_en  = 1'b1;
				end else begin
					status = ST_NONE;
				end
			end
			OP_FREE: begin
				if (!rel_ok || !alloc_map_q[rel_s1] || fq_sts.full) begin
					status = ST_NOT_ALLOC;
				end else begin
					clr_en   = 1'b1;
					push_req = 1'b1;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign fq_ctl.push = adv && push_req;
	assign fq_ctl.pop  = adv && pop_req;

	fhpa_free_fifo #(
		.POOL_SIZE (POOL_SIZE),
		.HW        (HW),
		.CW        (CW)
	) u_free_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (fq_ctl),
		.wdata     (rel_s1),
		.head_data (head_data),
		.sts       (fq_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_map_q <= '0;
			fresh_q     <= '0;
		end else if (adv) begin
			if (set_en) begin
				alloc_map_q[set_idx] <= 1'b1;
			end
			if (clr_en) begin
				alloc_map_q[rel_s1] <= 1'b0;
			end
			if (fresh_inc) begin
				fresh_q <= fresh_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (adv) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grant_q  <= grant;
			status_q <= status;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = OUT_W'({status_q, grant_q});

	`FHPA_ASSERT_ALWAYS(a_fresh_bound, fresh_q <= CW'(POOL_SIZE), "fresh counter beyond pool")
	`FHPA_ASSERT_IMPLY(a_pop_unallocated, fq_ctl.pop, !alloc_map_q[head_data], "freed handle already allocated")
	`FHPA_ASSERT_NEXT(a_result_loaded, adv, m_vld_q, "result register not loaded")

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the handle pool allocator. A predictor keeps its own
// allocated map, free list and fresh counter and queues the expected grant
// for every accepted request beat; each result beat is checked against the
// oldest one. Covers directed corner cases, a full exhaust/release/reuse
// cycle and random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;
	import fhpa_pkg::*;

	localparam int POOL = POOL_SIZE_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [5:0] handle;
		status_t    status;
	} grant_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;   // operation[1:0], release_handle[7:2]
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // granted_handle[5:0], status[7:6]

	// predictor state
	bit         pool_map [POOL];
	logic [5:0] free_list [POOL];
	logic [5:0] fl_head;
	logic [5:0] fl_tail;
	logic [6:0] fl_count;
	logic [6:0] fresh_next;

	grant_t expected_grants [$];
	int     fail_count = 0;
	int     src_idle_pct = 0;
	int     sink_stall_pct = 0;

	fifo_handle_pool_allocator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: errors");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic grant_t predict_grant(logic [1:0] op, logic [5:0] h);
		grant_t g;
		g.handle = 6'd0;
		g.status = ST_OK;
		if (op == OP_ALLOC || op == OP_TRY) begin
			if (fl_count != 0) begin
				g.handle = free_list[fl_head];
				fl_head = fl_head + 6'd1;
				fl_count = fl_count - 7'd1;
				pool_map[g.handle] = 1'b1;
			end else if (op == OP_TRY) begin
				g.status = ST_NONE;
			end else if (fresh_next < POOL) begin
				g.handle = fresh_next[5:0];
				pool_map[g.handle] = 1'b1;
				fresh_next = fresh_next + 7'd1;
			end else begin
				g.status = ST_EXHAUSTED;
			end
		end else if (op == OP_FREE) begin
			if (!pool_map[h] || fl_count >= POOL) begin
				g.status = ST_NOT_ALLOC;
			end else begin
				pool_map[h] = 1'b0;
				free_list[fl_tail] = h;
				fl_tail = fl_tail + 6'd1;
				fl_count = fl_count + 7'd1;
			end
		end
		return g;
	endfunction

	function automatic logic [5:0] pick_live_handle();
		int start;
		int idx;
		start = $urandom_range(POOL - 1);
		for (int i = 0; i < POOL; i++) begin
			idx = (start + i) % POOL;
			if (pool_map[idx])
				return idx[5:0];
		end
		return start[5:0];
	endfunction

	// called at a falling edge; returns at a falling edge
	task automatic send_request(input logic [1:0] op, input logic [5:0] h);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {h, op};
		do @(posedge clk); while (!s_tready);
		expected_grants.push_back(predict_grant(op, h));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (expected_grants.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_grants.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				exp_g = expected_grants.pop_front();
				if (m_tdata[5:0] !== exp_g.handle) begin
					$error("granted_handle: expected %0d, got %0d",
						exp_g.handle, m_tdata[5:0]);
					fail_count++;
				end
				if (m_tdata[7:6] !== exp_g.status) begin
					$error("status: expected %0d, got %0d",
						exp_g.status, m_tdata[7:6]);
					fail_count++;
				end
			end
		end
	end

	task automatic test_directed();
		src_idle_pct   = 14;
		sink_stall_pct = 14;
		send_request(OP_TRY, 6'd0);
		send_request(OP_FREE, 6'd0);
		send_request(OP_FREE, 6'd63);
		send_request(OP_UNUSED, 6'd63);
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_ALLOC, 6'd63);
		send_request(OP_FREE, 6'd1);
		send_request(OP_FREE, 6'd1);
		send_request(OP_TRY, 6'd63);
		send_request(OP_FREE, 6'd0);
		send_request(OP_FREE, 6'd2);
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_TRY, 6'd0);
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_FREE, 6'd3);
		send_request(OP_UNUSED, 6'd0);
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_FREE, 6'd63);
	endtask

	// issue every fresh handle, hit exhaustion, fill the free list, reuse all
	task automatic test_pool_exhaustion();
		logic [5:0] order [POOL];
		logic [5:0] tmp;
		int j;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		while (fresh_next < POOL)
			send_request(OP_ALLOC, 6'($urandom_range(63)));
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_ALLOC, 6'd63);
		send_request(OP_TRY, 6'd0);
		for (int i = 0; i < POOL; i++)
			order[i] = i[5:0];
		for (int i = POOL - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < POOL; i++)
			send_request(OP_FREE, order[i]);
		send_request(OP_FREE, 6'($urandom_range(63)));
		send_request(OP_ALLOC, 6'd0);
		send_request(OP_FREE, pick_live_handle());
		for (int i = 0; i < POOL; i++)
			send_request(OP_TRY, 6'($urandom_range(63)));
		send_request(OP_TRY, 6'd0);
		send_request(OP_ALLOC, 6'd0);
	endtask

	task automatic test_random_mix(input int n, input int src_pct, input int sink_pct);
		int r;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_drained();
			r = $urandom_range(99);
			if (r < 35)
				send_request(OP_ALLOC, 6'($urandom_range(63)));
			else if (r < 50)
				send_request(OP_TRY, 6'($urandom_range(63)));
			else if (r < 85)
				send_request(OP_FREE, pick_live_handle());
			else if (r < 95)
				send_request(OP_FREE, 6'($urandom_range(63)));
			else
				send_request(OP_UNUSED, 6'($urandom_range(63)));
		end
	endtask

	initial begin
		for (int i = 0; i < POOL; i++) begin
			pool_map[i]  = 1'b0;
			free_list[i] = 6'd0;
		end
		fl_head    = 6'd0;
		fl_tail    = 6'd0;
		fl_count   = 7'd0;
		fresh_next = 7'd0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_pool_exhaustion();
		test_random_mix(300, 0, 0);
		test_random_mix(300, 48, 0);
		test_random_mix(300, 0, 48);
		test_random_mix(300, 14, 14);

		wait_drained();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && expected_grants.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/fhpa_pkg.sv
hdl/fhpa_free_fifo.sv
hdl/fifo_handle_pool_allocator.sv
test/tb.sv
